[rtl/c_subset_lexer_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the C subset lexer.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_TOP_DEFINES_SVH
`define C_SUBSET_LEXER_TOP_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define CSL_ASSERT_CLK(clk, rstn, lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define CSL_ASSERT(lbl, prop, msg) \
    `CSL_ASSERT_CLK(aclk, aresetn, lbl, prop, msg)

`endif

[rtl/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Types, codes, tables and decode functions for the C subset lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    // Text length limit; positions saturate one below it, or at 65535.
    localparam int unsigned MAX_TEXT  = 65536;
    localparam int unsigned POS_MAX_I = (MAX_TEXT - 1 < 65535) ? (MAX_TEXT - 1) : 65535;
    localparam logic [15:0] POS_MAX   = 16'(POS_MAX_I);
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;
    localparam logic [62:0] NUM_MAX   = {63{1'b1}};

    // Token kinds.
    localparam logic [2:0] KIND_RESERVED = 3'd0;
    localparam logic [2:0] KIND_IDENT    = 3'd1;
    localparam logic [2:0] KIND_NUMBER   = 3'd2;
    localparam logic [2:0] KIND_END      = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // Pending token classes.
    localparam logic [2:0] PC_NONE  = 3'd0;
    localparam logic [2:0] PC_IDENT = 3'd1;
    localparam logic [2:0] PC_NUM   = 3'd2;
    localparam logic [2:0] PC_LT    = 3'd3;
    localparam logic [2:0] PC_GT    = 3'd4;
    localparam logic [2:0] PC_EQ    = 3'd5;
    localparam logic [2:0] PC_BANG  = 3'd6;

    // Reserved symbol codes.
    localparam logic [4:0] SYM_PLUS   = 5'd0;
    localparam logic [4:0] SYM_MINUS  = 5'd1;
    localparam logic [4:0] SYM_STAR   = 5'd2;
    localparam logic [4:0] SYM_SLASH  = 5'd3;
    localparam logic [4:0] SYM_LPAREN = 5'd4;
    localparam logic [4:0] SYM_RPAREN = 5'd5;
    localparam logic [4:0] SYM_LT     = 5'd6;
    localparam logic [4:0] SYM_GT     = 5'd7;
    localparam logic [4:0] SYM_SEMI   = 5'd8;
    localparam logic [4:0] SYM_ASSIGN = 5'd9;
    localparam logic [4:0] SYM_LBRACE = 5'd10;
    localparam logic [4:0] SYM_RBRACE = 5'd11;
    localparam logic [4:0] OP_EQEQ    = 5'd12;
    localparam logic [4:0] OP_NE      = 5'd13;
    localparam logic [4:0] OP_LE      = 5'd14;
    localparam logic [4:0] OP_GE      = 5'd15;
    localparam logic [4:0] KW_BASE    = 5'd16;

    localparam int unsigned NUM_KW = 5;
    localparam int unsigned KW_MAXLEN = 6;

    // Keywords: return, if, else, for, while.
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXLEN] = '{
        '{"r", "e", "t", "u", "r", "n"},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd2, 3'd4, 3'd3, 3'd5};

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  code;
        logic [15:0] start;
        logic [15:0] len;
        logic [62:0] value;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } sym_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b >= 8'd9 && b <= 8'd13) || b == " ";
    endfunction

    // One-byte symbols that are emitted at once; < > = ! go through lookahead.
    function automatic sym_t sym_lookup(input logic [7:0] b);
        sym_t s;
        s.hit = 1'b1;
        unique case (b)
            "+":     s.code = SYM_PLUS;
            "-":     s.code = SYM_MINUS;
            "*":     s.code = SYM_STAR;
            "/":     s.code = SYM_SLASH;
            "(":     s.code = SYM_LPAREN;
            ")":     s.code = SYM_RPAREN;
            ";":     s.code = SYM_SEMI;
            "{":     s.code = SYM_LBRACE;
            "}":     s.code = SYM_RBRACE;
            default: begin
                s.hit  = 1'b0;
                s.code = SYM_PLUS;
            end
        endcase
        return s;
    endfunction

    // Narrows the keyword candidates with the byte at offset idx.
    function automatic logic [4:0] match_kw(input logic [4:0] cand, input logic [15:0] idx,
                                            input logic [7:0] b);
        logic [4:0] res;
        res = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            if (cand[i] && idx < {13'd0, KW_LEN[i]} && KW_TEXT[i][idx[2:0]] == b) begin
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    // Token produced when the pending token is closed.
    function automatic tok_t flush_token(input logic [2:0] pc, input logic [15:0] start,
                                         input logic [15:0] len, input logic [62:0] acc,
                                         input logic [4:0] cand);
        tok_t t;
        logic found;
        t       = '0;
        t.start = start;
        t.len   = 16'd1;
        found   = 1'b0;
        case (pc)
            PC_IDENT: begin
                t.kind = KIND_IDENT;
                t.len  = len;
                for (int i = 0; i < NUM_KW; i++) begin
                    if (!found && cand[i] && len == {13'd0, KW_LEN[i]}) begin
                        found  = 1'b1;
                        t.kind = KIND_RESERVED;
                        t.code = KW_BASE + 5'(i);
                    end
                end
            end
            PC_NUM: begin
                t.kind  = KIND_NUMBER;
                t.len   = len;
                t.value = acc;
            end
            PC_LT: begin
                t.kind = KIND_RESERVED;
                t.code = SYM_LT;
            end
            PC_GT: begin
                t.kind = KIND_RESERVED;
                t.code = SYM_GT;
            end
            PC_EQ: begin
                t.kind = KIND_RESERVED;
                t.code = SYM_ASSIGN;
            end
            PC_BANG: begin
                t.kind = KIND_ERROR;
                t.last = 1'b1;
            end
            default: begin
                t.kind = KIND_RESERVED;
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/c_subset_lexer_top.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer_top
// Byte-serial lexer for a small C subset with one token of lookahead.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one source byte per item, or an end-of-text marker.
// The m_ channel carries tokens: kind, reserved code, start, length, value and
// a last flag on the end and error tokens.
// Each accepted item is decoded in the cycle it is accepted and its tokens
// are written into a three-entry result queue, so a token is queued from the
// cycle after the item that closes it. An item may close the pending token
// and emit its own, giving two tokens.
// Throughput is one item per cycle while the receiver keeps up and items give
// at most one token each; an item giving two tokens can lower s_ready.
// s_ready is low while two or more tokens wait in the queue, so a stalled
// receiver stops the input after at most two further token-giving items, with
// up to three tokens held.
// Reset clears the pending token, the position counter, the error flag and
// the queue. An end item resets all of these but the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "c_subset_lexer_top_defines.svh"

module c_subset_lexer_top
    import csl_pkg::*;
#(
    parameter int unsigned MAX_TEXT = csl_pkg::MAX_TEXT
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_token_kind,
    output logic [4:0]       m_symbol_code,
    output logic [15:0]      m_start_position,
    output logic [15:0]      m_token_length,
    output logic [62:0]      m_number_value,
    output logic             m_last_of_text
);

    // Positions saturate one below the text limit, or at 65535.
    localparam logic [15:0] POS_LIMIT = 16'((MAX_TEXT - 1 < 65535) ? (MAX_TEXT - 1) : 65535);

    // Lexer state.
    logic [2:0]  pc_reg,   pc_next;
    logic [15:0] pstart_reg, pstart_next;
    logic [15:0] plen_reg, plen_next;
    logic [62:0] acc_reg,  acc_next;
    logic [4:0]  cand_reg, cand_next;
    logic [15:0] pos_reg,  pos_next;
    logic        err_reg,  err_next;

    // Result queue.
    tok_t        fifo_reg [3];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    logic        accept;
    logic        pop;
    logic [1:0]  n_res;
    tok_t        res0, res1;
    logic [1:0]  wr_ptr_p1;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    assign accept    = s_valid && s_ready;
    assign pop       = m_valid && m_ready;
    assign s_ready   = count_reg <= 2'd1;
    assign m_valid   = count_reg != 2'd0;
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    assign m_token_kind     = fifo_reg[rd_ptr_reg].kind;
    assign m_symbol_code    = fifo_reg[rd_ptr_reg].code;
    assign m_start_position = fifo_reg[rd_ptr_reg].start;
    assign m_token_length   = fifo_reg[rd_ptr_reg].len;
    assign m_number_value   = fifo_reg[rd_ptr_reg].value;
    assign m_last_of_text   = fifo_reg[rd_ptr_reg].last;

    always_comb begin
        tok_t        flush_tok;
        tok_t        end_tok;
        tok_t        new_tok;
        logic        flush_vld;
        logic        new_vld;
        logic        let_b;
        logic        dig_b;
        logic [66:0] acc_mul;
        sym_t        sym;

        pc_next     = pc_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        acc_next    = acc_reg;
        cand_next   = cand_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        res0        = '0;
        res1        = '0;
        n_res       = 2'd0;

        flush_tok = flush_token(pc_reg, pstart_reg, plen_reg, acc_reg, cand_reg);
        flush_vld = pc_reg != PC_NONE;
        let_b     = is_letter(s_text_byte);
        dig_b     = is_digit(s_text_byte);
        sym       = sym_lookup(s_text_byte);

        end_tok       = '0;
        end_tok.kind  = KIND_END;
        end_tok.start = pos_reg;
        end_tok.last  = 1'b1;

        new_tok       = '0;
        new_tok.start = pos_reg;
        new_tok.len   = 16'd1;
        new_vld       = 1'b0;

        // Ten times the accumulator plus the digit; exact in 67 bits.
        acc_mul = {1'b0, acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0} + {63'd0, s_text_byte[3:0]};

        if (accept) begin
            if (s_end_of_text) begin
                if (!err_reg && flush_vld) begin
                    res0  = flush_tok;
                    res1  = end_tok;
                    n_res = 2'd2;
                end else begin
                    res0  = end_tok;
                    n_res = 2'd1;
                end
                pc_next     = PC_NONE;
                pstart_next = '0;
                plen_next   = '0;
                acc_next    = '0;
                cand_next   = '1;
                pos_next    = '0;
                err_next    = 1'b0;
            end else begin
                if (pos_reg < POS_LIMIT) begin
                    pos_next = pos_reg + 16'd1;
                end
                if (!err_reg) begin
                    if (pc_reg == PC_IDENT && (let_b || dig_b)) begin
                        cand_next = match_kw(cand_reg, plen_reg, s_text_byte);
                        plen_next = (plen_reg == LEN_MAX) ? plen_reg : plen_reg + 16'd1;
                    end else if (pc_reg == PC_NUM && dig_b) begin
                        acc_next  = (acc_mul > {4'd0, NUM_MAX}) ? NUM_MAX : acc_mul[62:0];
                        plen_next = (plen_reg == LEN_MAX) ? plen_reg : plen_reg + 16'd1;
                    end else if (pc_reg >= PC_LT && s_text_byte == "=") begin
                        res0       = '0;
                        res0.kind  = KIND_RESERVED;
                        res0.start = pstart_reg;
                        res0.len   = 16'd2;
                        case (pc_reg)
                            PC_EQ:   res0.code = OP_EQEQ;
                            PC_BANG: res0.code = OP_NE;
                            PC_LT:   res0.code = OP_LE;
                            default: res0.code = OP_GE;
                        endcase
                        n_res       = 2'd1;
                        pc_next     = PC_NONE;
                        pstart_next = '0;
                        plen_next   = '0;
                        acc_next    = '0;
                        cand_next   = '1;
                    end else begin
                        // The byte closes the pending token, then starts its own unless it is blank or a bang was held.
                        pc_next     = PC_NONE;
                        pstart_next = '0;
                        plen_next   = '0;
                        acc_next    = '0;
                        cand_next   = '1;
                        if (flush_vld) begin
                            res0  = flush_tok;
                            n_res = 2'd1;
                        end
                        if (pc_reg == PC_BANG) begin
                            err_next = 1'b1;
                        end else if (is_space(s_text_byte)) begin
                            new_vld = 1'b0;
                        end else if (s_text_byte == "<" || s_text_byte == ">" ||
                                     s_text_byte == "=" || s_text_byte == "!") begin
                            case (s_text_byte)
                                "<":     pc_next = PC_LT;
                                ">":     pc_next = PC_GT;
                                "=":     pc_next = PC_EQ;
                                default: pc_next = PC_BANG;
                            endcase
                            pstart_next = pos_reg;
                            plen_next   = 16'd1;
                        end else if (sym.hit) begin
                            new_vld      = 1'b1;
                            new_tok.kind = KIND_RESERVED;
                            new_tok.code = sym.code;
                        end else if (let_b) begin
                            pc_next     = PC_IDENT;
                            pstart_next = pos_reg;
                            plen_next   = 16'd1;
                            cand_next   = match_kw('1, 16'd0, s_text_byte);
                        end else if (dig_b) begin
                            pc_next     = PC_NUM;
                            pstart_next = pos_reg;
                            plen_next   = 16'd1;
                            acc_next    = {59'd0, s_text_byte[3:0]};
                        end else begin
                            new_vld      = 1'b1;
                            new_tok.kind = KIND_ERROR;
                            new_tok.last = 1'b1;
                            err_next     = 1'b1;
                        end
                        if (new_vld) begin
                            if (flush_vld) begin
                                res1  = new_tok;
                                n_res = 2'd2;
                            end else begin
                                res0  = new_tok;
                                n_res = 2'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (n_res == 2'd1) begin
            wr_ptr_next = wr_ptr_p1;
        end else if (n_res == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_p1);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + n_res - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= PC_NONE;
            pstart_reg <= '0;
            plen_reg   <= '0;
            acc_reg    <= '0;
            cand_reg   <= '1;
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            pc_reg     <= pc_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            acc_reg    <= acc_next;
            cand_reg   <= cand_next;
            pos_reg    <= pos_next;
            err_reg    <= err_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_ptr_p1] <= res1;
        end
    end

    // An end item clears the position, the pending token and the error flag.
    `CSL_ASSERT(a_end_clears, (accept && s_end_of_text) |=> (pos_reg == 16'd0 && pc_reg == PC_NONE && !err_reg), "end item did not clear lexer state")

    // Once an error is seen nothing stays pending.
    `CSL_ASSERT(a_err_no_pending, err_reg |-> (pc_reg == PC_NONE), "pending token held after an error")

    // Only number tokens carry a value.
    `CSL_ASSERT(a_value_kind, (m_valid && m_token_kind != KIND_NUMBER) |-> (m_number_value == 63'd0), "value on a token that is not a number")

    // A pop with nothing written shrinks the queue by one.
    `CSL_ASSERT(a_queue_pop, (!accept && pop) |=> (count_reg == $past(count_reg) - 2'd1), "queue occupancy lost track")

endmodule

`default_nettype wire

[verif/c_subset_lexer_checker.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer_checker
// Watches both channels of the lexer, predicts the tokens that every accepted
// item should produce and compares each token on the result side, in order,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_subset_lexer_checker
    import csl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_end_of_text,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [2:0]  m_token_kind,
    input  wire logic [4:0]  m_symbol_code,
    input  wire logic [15:0] m_start_position,
    input  wire logic [15:0] m_token_length,
    input  wire logic [62:0] m_number_value,
    input  wire logic        m_last_of_text,
    output int unsigned      error_count,
    output int unsigned      tokens_outstanding
);

    localparam logic [4:0] NO_CODE = 5'd0;

    string keyword_spell [5] = '{"return", "if", "else", "for", "while"};

    tok_t expected_tokens [$];

    // Lexer state as the block should hold it.
    logic [2:0]  lex_class;
    logic [15:0] lex_start;
    logic [15:0] lex_len;
    logic [62:0] lex_value;
    logic [4:0]  kw_match;
    logic [15:0] text_pos;
    logic        text_failed;

    function automatic logic letter_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic blank_byte(input logic [7:0] b);
        return (b >= 8'd9 && b <= 8'd13) || b == " ";
    endfunction

    function automatic logic [4:0] narrow_keywords(input logic [4:0] cand,
                                                   input logic [15:0] idx,
                                                   input logic [7:0] b);
        logic [4:0] res;
        res = '0;
        for (int k = 0; k < 5; k++) begin
            if (cand[k] && idx < keyword_spell[k].len()) begin
                if (keyword_spell[k][idx] == b) begin
                    res[k] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic void queue_token(input logic [2:0] kind, input logic [4:0] code,
                                        input logic [15:0] start, input logic [15:0] len,
                                        input logic [62:0] value, input logic last);
        tok_t t;
        t.kind  = kind;
        t.code  = code;
        t.start = start;
        t.len   = len;
        t.value = value;
        t.last  = last;
        expected_tokens.push_back(t);
    endfunction

    function automatic void clear_pending();
        lex_class = PC_NONE;
        lex_start = '0;
        lex_len   = '0;
        lex_value = '0;
        kw_match  = 5'h1F;
    endfunction

    function automatic void restart_text();
        clear_pending();
        text_pos    = '0;
        text_failed = 1'b0;
    endfunction

    function automatic void open_pending(input logic [2:0] cls, input logic [15:0] pos);
        lex_class = cls;
        lex_start = pos;
        lex_len   = 16'd1;
    endfunction

    // Emits whatever token is held; a held bang turns into an error.
    function automatic void close_pending();
        logic hit;
        hit = 1'b0;
        case (lex_class)
            PC_IDENT: begin
                for (int k = 0; k < 5; k++) begin
                    if (!hit && kw_match[k] && lex_len == keyword_spell[k].len()) begin
                        hit = 1'b1;
                        queue_token(KIND_RESERVED, KW_BASE + 5'(k), lex_start, lex_len, '0,
                                    1'b0);
                    end
                end
                if (!hit) begin
                    queue_token(KIND_IDENT, NO_CODE, lex_start, lex_len, '0, 1'b0);
                end
            end
            PC_NUM:  queue_token(KIND_NUMBER, NO_CODE, lex_start, lex_len, lex_value, 1'b0);
            PC_LT:   queue_token(KIND_RESERVED, SYM_LT, lex_start, 16'd1, '0, 1'b0);
            PC_GT:   queue_token(KIND_RESERVED, SYM_GT, lex_start, 16'd1, '0, 1'b0);
            PC_EQ:   queue_token(KIND_RESERVED, SYM_ASSIGN, lex_start, 16'd1, '0, 1'b0);
            PC_BANG: begin
                queue_token(KIND_ERROR, NO_CODE, lex_start, 16'd1, '0, 1'b1);
                text_failed = 1'b1;
            end
            default: ;
        endcase
        clear_pending();
    endfunction

    function automatic void lex_item(input logic [7:0] b, input logic eot);
        logic [15:0] pos;
        logic [63:0] d;
        logic [63:0] wide;
        logic [4:0]  code;
        pos = text_pos;
        if (eot) begin
            if (!text_failed) begin
                close_pending();
            end
            queue_token(KIND_END, NO_CODE, pos, 16'd0, '0, 1'b1);
            restart_text();
            return;
        end
        if (text_pos < POS_MAX) begin
            text_pos++;
        end
        if (text_failed) begin
            return;
        end
        if (lex_class == PC_IDENT && (letter_byte(b) || digit_byte(b))) begin
            kw_match = narrow_keywords(kw_match, lex_len, b);
            if (lex_len != LEN_MAX) begin
                lex_len++;
            end
            return;
        end
        if (lex_class == PC_NUM && digit_byte(b)) begin
            d = 64'(b - "0");
            if ({1'b0, lex_value} > ({1'b0, NUM_MAX} - d) / 64'd10) begin
                lex_value = NUM_MAX;
            end else begin
                wide      = {1'b0, lex_value} * 64'd10 + d;
                lex_value = wide[62:0];
            end
            if (lex_len != LEN_MAX) begin
                lex_len++;
            end
            return;
        end
        if (lex_class >= PC_LT && b == "=") begin
            case (lex_class)
                PC_EQ:   code = OP_EQEQ;
                PC_BANG: code = OP_NE;
                PC_LT:   code = OP_LE;
                default: code = OP_GE;
            endcase
            queue_token(KIND_RESERVED, code, lex_start, 16'd2, '0, 1'b0);
            clear_pending();
            return;
        end

        close_pending();
        if (text_failed || blank_byte(b)) begin
            return;
        end
        case (b)
            "<": open_pending(PC_LT, pos);
            ">": open_pending(PC_GT, pos);
            "=": open_pending(PC_EQ, pos);
            "!": open_pending(PC_BANG, pos);
            "+": queue_token(KIND_RESERVED, SYM_PLUS, pos, 16'd1, '0, 1'b0);
            "-": queue_token(KIND_RESERVED, SYM_MINUS, pos, 16'd1, '0, 1'b0);
            "*": queue_token(KIND_RESERVED, SYM_STAR, pos, 16'd1, '0, 1'b0);
            "/": queue_token(KIND_RESERVED, SYM_SLASH, pos, 16'd1, '0, 1'b0);
            "(": queue_token(KIND_RESERVED, SYM_LPAREN, pos, 16'd1, '0, 1'b0);
            ")": queue_token(KIND_RESERVED, SYM_RPAREN, pos, 16'd1, '0, 1'b0);
            ";": queue_token(KIND_RESERVED, SYM_SEMI, pos, 16'd1, '0, 1'b0);
            "{": queue_token(KIND_RESERVED, SYM_LBRACE, pos, 16'd1, '0, 1'b0);
            "}": queue_token(KIND_RESERVED, SYM_RBRACE, pos, 16'd1, '0, 1'b0);
            default: begin
                if (letter_byte(b)) begin
                    open_pending(PC_IDENT, pos);
                    kw_match = narrow_keywords(5'h1F, 16'd0, b);
                end else if (digit_byte(b)) begin
                    open_pending(PC_NUM, pos);
                    lex_value = 63'(b - "0");
                end else begin
                    queue_token(KIND_ERROR, NO_CODE, pos, 16'd1, '0, 1'b1);
                    text_failed = 1'b1;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input tok_t want, input tok_t seen);
        if (error_count < 10) begin
            $display("%0t: %s: expected kind %0d code %0d start %0d len %0d value %0d last %0d",
                     $time, what, want.kind, want.code, want.start, want.len, want.value,
                     want.last);
            $display("%0t: %s: got      kind %0d code %0d start %0d len %0d value %0d last %0d",
                     $time, what, seen.kind, seen.code, seen.start, seen.len, seen.value,
                     seen.last);
        end
        error_count++;
    endtask

    // The result side is checked before the item of the same edge is taken in;
    // a token can never leave in the cycle its item arrives.
    always @(posedge aclk) begin
        tok_t seen;
        tok_t want;
        if (!aresetn) begin
            restart_text();
            expected_tokens.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.kind  = m_token_kind;
                seen.code  = m_symbol_code;
                seen.start = m_start_position;
                seen.len   = m_token_length;
                seen.value = m_number_value;
                seen.last  = m_last_of_text;
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected token", '0, seen);
                end else begin
                    want = expected_tokens.pop_front();
                    if (seen.kind !== want.kind || seen.code !== want.code ||
                        seen.start !== want.start || seen.len !== want.len ||
                        seen.value !== want.value || seen.last !== want.last) begin
                        report_mismatch("token mismatch", want, seen);
                    end
                end
            end
            if (s_valid && s_ready) begin
                lex_item(s_text_byte, s_end_of_text);
            end
        end
        tokens_outstanding = expected_tokens.size();
    end

endmodule

[verif/c_subset_lexer_top_test.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer_top_test
// Feeds the lexer short directed texts, then random texts built mostly from
// valid lexemes with some raw noise. Both sides idle at random; the checker
// beside the block does all the comparing.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_subset_lexer_top_test;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_end_of_text;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_token_kind;
    logic [4:0]  m_symbol_code;
    logic [15:0] m_start_position;
    logic [15:0] m_token_length;
    logic [62:0] m_number_value;
    logic        m_last_of_text;

    int unsigned check_errors;
    int unsigned tokens_left;

    logic        item_taken = 1'b0;
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;

    string word_pool [14] = '{"return", "if", "else", "for", "while", "retur", "iff", "els",
                              "fo", "whiles", "ifelse", "_", "x", "returns"};
    string sym_pool [17]  = '{"+", "-", "*", "/", "(", ")", "<", ">", ";", "=", "{", "}",
                              "==", "!=", "<=", ">=", "!"};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    c_subset_lexer_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_end_of_text    (s_end_of_text),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_symbol_code    (m_symbol_code),
        .m_start_position (m_start_position),
        .m_token_length   (m_token_length),
        .m_number_value   (m_number_value),
        .m_last_of_text   (m_last_of_text)
    );

    c_subset_lexer_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_text_byte        (s_text_byte),
        .s_end_of_text      (s_end_of_text),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_token_kind       (m_token_kind),
        .m_symbol_code      (m_symbol_code),
        .m_start_position   (m_start_position),
        .m_token_length     (m_token_length),
        .m_number_value     (m_number_value),
        .m_last_of_text     (m_last_of_text),
        .error_count        (check_errors),
        .tokens_outstanding (tokens_left)
    );

    always @(posedge aclk) begin
        item_taken <= s_valid && s_ready;
    end

    // Receiver: stall density is redrawn whenever its mode runs out, and at fixed
    // points it holds off long enough for the block to back up its input.
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned ready_pct = 100;

    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle == 600 || rx_cycle == 2200 || rx_cycle == 4000) begin
            hold_left = 120;
        end
        if (mode_left == 0) begin
            mode_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0:       ready_pct = 100;
                1:       ready_pct = 70;
                2:       ready_pct = 40;
                default: ready_pct = 10;
            endcase
        end
        mode_left--;
        if (hold_left != 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Called and returning at a falling edge; valid stays high between items
    // of one burst.
    task automatic send_item(input logic [7:0] b, input logic eot);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       = 1'b1;
        s_text_byte   = b;
        s_end_of_text = eot;
        do @(negedge aclk); while (!item_taken);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic end_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (tokens_left != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] ident_byte(input bit first);
        int unsigned r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r == 52) begin
            return "_";
        end
        return 8'("0" + r - 53);
    endfunction

    task automatic send_blank();
        int unsigned w;
        w = $urandom_range(0, 5);
        send_item((w == 5) ? 8'd32 : 8'(9 + w), 1'b0);
    endtask

    task automatic send_lexeme();
        int unsigned n;
        case ($urandom_range(0, 9))
            0, 1: send_text(word_pool[$urandom_range(0, 13)]);
            2, 3: begin
                n = $urandom_range(0, 7);
                send_item(ident_byte(1'b1), 1'b0);
                repeat (n) send_item(ident_byte(1'b0), 1'b0);
            end
            4, 5: begin
                // Mostly short numbers; now and then one long enough that it may saturate.
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 22)
                                                : $urandom_range(1, 5);
                repeat (n) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            default: send_text(sym_pool[$urandom_range(0, 16)]);
        endcase
    endtask

    initial begin
        int unsigned n;
        s_valid       = 1'b0;
        s_text_byte   = 8'd0;
        s_end_of_text = 1'b0;
        aresetn       = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Overflowing number, then an end item.
        send_text("9999999999999999999");
        send_item(8'h00, 1'b1);
        // Lone bang: the letter after it and everything else is ignored.
        send_text("!a");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        // A bang still held when the end arrives.
        send_text("<!");
        send_item(8'hFF, 1'b1);
        // Unknown bytes at both extremes, one closing a held identifier.
        send_text("x");
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h41, 1'b1);
        wait_drained();

        while (items_sent < 720) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 30);
                repeat (n) begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                end
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    send_lexeme();
                    if ($urandom_range(0, 3) != 0) begin
                        send_blank();
                    end
                end
            end
            end_text();
        end

        wait_drained();
        repeat (16) @(negedge aclk);
        if (check_errors == 0 && tokens_left == 0) begin
            $display("c_subset_lexer_top test passed");
        end else begin
            $display("c_subset_lexer_top test failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("c_subset_lexer_top test failed");
        $finish;
    end

endmodule
